### rtl/core/checksummed_packet_receiver_defines.svh
// assertion macros shared by the checker
`ifndef CHECKSUMMED_PACKET_RECEIVER_DEFINES_SVH
`define CHECKSUMMED_PACKET_RECEIVER_DEFINES_SVH

// implication checked on every edge outside reset
`define CPR_CHK(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("cpr checker: property failed");

// property that must also hold while reset is applied
`define CPR_CHK_RST(label, prop) \
  label: assert property (@(posedge clk) (prop)) \
    else $error("cpr checker: reset property failed");

`endif

### rtl/core/cpr_pkg.sv
`default_nettype none
package cpr_pkg;

  localparam int MAX_PAYLOAD = 32;
  localparam int BUF_DEPTH   = MAX_PAYLOAD + 4;
  localparam int IDX_W       = $clog2(BUF_DEPTH);
  localparam int CNT_W       = $clog2(BUF_DEPTH + 1);
  localparam int RD_IDX_W    = 6;
  localparam int ERR_LEN     = 9;
  localparam int ERR_W       = $clog2(ERR_LEN);
  localparam int ROUTE_OFS   = 6;
  localparam int CMD_POS     = 5;

  localparam logic [7:0] SYNC0      = 8'hAA;
  localparam logic [7:0] SYNC1      = 8'h55;
  localparam logic [7:0] CMD_ORDER  = 8'h01;
  localparam logic [7:0] CMD_ROUTE  = 8'h07;
  localparam logic [7:0] CMD_NOSAVE = 8'h03;

  localparam logic [1:0] KIND_ECHO = 2'd0;
  localparam logic [1:0] KIND_ERR  = 2'd1;
  localparam logic [1:0] KIND_READ = 2'd2;

  localparam logic [1:0] STORE_ORDER = 2'd0;
  localparam logic [1:0] STORE_ROUTE = 2'd1;
  localparam logic [1:0] STORE_CMD   = 2'd2;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CHECK,
    S_SUM,
    S_SUM_LAST,
    S_DECIDE,
    S_ERR,
    S_ECHO_RD,
    S_ECHO_WR,
    S_READ,
    S_READ_OUT
  } state_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] data;
    logic       last;
    logic       ok;
    logic [7:0] turns;
  } out_item_t;

  typedef struct packed {
    logic clear;
    logic add;
  } acc_ctrl_t;

  function automatic logic [7:0] err_byte(input logic [ERR_W-1:0] i);
    logic [7:0] b;
    case (i)
      ERR_W'(0): b = 8'hAA;
      ERR_W'(1): b = 8'h55;
      ERR_W'(2): b = 8'h06;
      ERR_W'(3): b = 8'h00;
      ERR_W'(4): b = 8'h01;
      ERR_W'(5): b = 8'hC1;
      ERR_W'(6): b = 8'h00;
      ERR_W'(7): b = 8'h01;
      ERR_W'(8): b = 8'hC8;
      default:   b = 8'h00;
    endcase
    return b;
  endfunction

endpackage
`default_nettype wire

### rtl/core/cpr_ram.sv
`default_nettype none
module cpr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 36,
  localparam int AW = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

### rtl/core/cpr_accum.sv
`default_nettype none
module cpr_accum (
  input  wire logic              clk,
  input  wire cpr_pkg::acc_ctrl_t ctrl,
  input  wire logic [7:0]        data,
  input  wire logic [7:0]        ref_byte,
  output logic                   match
);
  import cpr_pkg::*;

  logic [7:0] acc;

  // modulo-256 running sum
  always_ff @(posedge clk) begin
    if (ctrl.clear) begin
      acc <= 8'h00;
    end else if (ctrl.add) begin
      acc <= acc + data;
    end
  end

  assign match = (acc == ref_byte);

endmodule
`default_nettype wire

### rtl/core/cpr_out_reg.sv
`default_nettype none
module cpr_out_reg (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               load,
  input  wire cpr_pkg::out_item_t item_d,
  input  wire logic               stall,
  output logic                    valid,
  output cpr_pkg::out_item_t      item_q,
  output logic                    free
);
  import cpr_pkg::*;

  assign free = !valid || !stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load) begin
      valid <= 1'b1;
    end else if (!stall) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      item_q <= item_d;
    end
  end

endmodule
`default_nettype wire

### rtl/core/checksummed_packet_receiver.sv
// checksummed packet receiver
// input channel (in_valid/in_stall) carries one request per item: action 0
// pushes rx_byte into the packet buffer, action 1 reads entry read_index of
// the store chosen by store_select. in_stall is high whenever the sequencer
// is busy; one request is worked on at a time.
// output channel (out_valid/out_stall) carries echo bytes, error reply bytes
// and read data through a single output register; last marks the final
// result of a request.
// steps after acceptance:
//   byte with no result: store, then header/length check
//   byte that ends a packet: checksum walk through the buffer memory with
//     the accumulator, then for each echoed byte a buffer read, then output
//     and store writes
//   error: after the header or checksum check, one reply byte per cycle while out_stall is low
//   read: registered store read, then output
// the checksum walk and the echo both go through the single buffer read port.
// out_stall holds the output register and pauses the sequencer; a new
// request is still taken while the final result waits.
// rst (synchronous) empties the buffer count, clears turns and the stored
// command byte, and marks every store entry as zero.
`default_nettype none
module checksummed_packet_receiver (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         in_valid,
  output logic                              in_stall,
  input  wire logic                         action,
  input  wire logic [7:0]                   rx_byte,
  input  wire logic [1:0]                   store_select,
  input  wire logic [cpr_pkg::RD_IDX_W-1:0] read_index,
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output logic [1:0]                        out_kind,
  output logic [7:0]                        out_byte,
  output logic                              last,
  output logic                              packet_ok,
  output logic [7:0]                        turn_count
);
  import cpr_pkg::*;

  state_t state, state_next;

  logic [CNT_W-1:0]    count, count_next;
  logic [IDX_W-1:0]    idx, idx_next;
  logic [ERR_W-1:0]    err_idx, err_idx_next;
  logic [7:0]          b0, b0_next;
  logic [7:0]          b1, b1_next;
  logic [7:0]          len, len_next;
  logic [7:0]          cmd, cmd_next;
  logic [7:0]          last_byte, last_byte_next;
  logic [7:0]          turns, turns_next;
  logic [1:0]          rd_sel, rd_sel_next;
  logic [RD_IDX_W-1:0] rd_idx, rd_idx_next;
  logic                rd_ok, rd_ok_next;

  logic [BUF_DEPTH-1:0] v_order, v_route, v_cmd;

  logic             buf_we;
  logic [7:0]       buf_rdata;
  logic             order_we, route_we, cmd_we;
  logic [IDX_W-1:0] route_waddr;
  logic [IDX_W-1:0] store_raddr;
  logic             rd_in_range;
  logic [7:0]       order_rdata, route_rdata, cmd_rdata;
  logic [7:0]       read_val;

  acc_ctrl_t acc_ctrl;
  logic      sum_match;

  logic      out_load, out_free;
  out_item_t out_d, out_q;

  logic accept, hdr_err, echo_last, err_last;

  assign in_stall = (state != S_IDLE);
  assign accept   = in_valid && (state == S_IDLE);

  assign rd_in_range = ({1'b0, rd_idx} < (RD_IDX_W + 1)'(BUF_DEPTH));
  assign store_raddr = rd_in_range ? IDX_W'(rd_idx) : '0;
  assign route_waddr = idx - IDX_W'(ROUTE_OFS);

  always_comb begin
    case (rd_sel)
      STORE_ORDER: read_val = order_rdata;
      STORE_ROUTE: read_val = route_rdata;
      STORE_CMD:   read_val = cmd_rdata;
      default:     read_val = 8'h00;
    endcase
  end

  assign echo_last = (CNT_W'(idx) == count - CNT_W'(1));
  assign err_last  = (err_idx == ERR_W'(ERR_LEN - 1));

  // header and overflow checks on the count after the new byte
  always_comb begin
    hdr_err = 1'b0;
    if (count == CNT_W'(BUF_DEPTH) || b0 != SYNC0) begin
      hdr_err = 1'b1;
    end else if (count > CNT_W'(3) && b1 != SYNC1) begin
      hdr_err = 1'b1;
    end
  end

  always_comb begin
    state_next     = state;
    count_next     = count;
    idx_next       = idx;
    err_idx_next   = err_idx;
    b0_next        = b0;
    b1_next        = b1;
    len_next       = len;
    cmd_next       = cmd;
    last_byte_next = last_byte;
    turns_next     = turns;
    rd_sel_next    = rd_sel;
    rd_idx_next    = rd_idx;
    rd_ok_next     = rd_ok;
    buf_we         = 1'b0;
    order_we       = 1'b0;
    route_we       = 1'b0;
    cmd_we         = 1'b0;
    acc_ctrl       = '0;
    out_load       = 1'b0;
    out_d          = '0;
    out_d.turns    = turns;

    case (state)
      S_IDLE: begin
        if (accept) begin
          if (action) begin
            rd_sel_next = store_select;
            rd_idx_next = read_index;
            state_next  = S_READ;
          end else begin
            buf_we         = 1'b1;
            last_byte_next = rx_byte;
            if (count == CNT_W'(0)) b0_next = rx_byte;
            if (count == CNT_W'(1)) b1_next = rx_byte;
            if (count == CNT_W'(2)) len_next = rx_byte;
            if (count == CNT_W'(CMD_POS)) cmd_next = rx_byte;
            count_next = count + CNT_W'(1);
            state_next = S_CHECK;
          end
        end
      end
      S_CHECK: begin
        if (hdr_err) begin
          count_next   = '0;
          err_idx_next = '0;
          state_next   = S_ERR;
        end else if (count > CNT_W'(3) && 9'(count) >= 9'(len) + 9'd3) begin
          idx_next       = '0;
          acc_ctrl.clear = 1'b1;
          state_next     = S_SUM;
        end else begin
          state_next = S_IDLE;
        end
      end
      S_SUM: begin
        // read data is registered, so it belongs to the previous address
        acc_ctrl.add = (idx != '0);
        idx_next     = idx + IDX_W'(1);
        if (CNT_W'(idx) == count - CNT_W'(2)) begin
          state_next = S_SUM_LAST;
        end
      end
      S_SUM_LAST: begin
        acc_ctrl.add = 1'b1;
        state_next   = S_DECIDE;
      end
      S_DECIDE: begin
        if (sum_match) begin
          idx_next = '0;
          if (cmd == CMD_ROUTE && count >= CNT_W'(ROUTE_OFS + 2)) begin
            turns_next = 8'(count) - 8'(ROUTE_OFS + 1);
          end
          state_next = S_ECHO_RD;
        end else begin
          count_next   = '0;
          err_idx_next = '0;
          state_next   = S_ERR;
        end
      end
      S_ECHO_RD: begin
        state_next = S_ECHO_WR;
      end
      S_ECHO_WR: begin
        if (out_free) begin
          out_load   = 1'b1;
          out_d.kind = KIND_ECHO;
          out_d.data = buf_rdata;
          out_d.last = echo_last;
          out_d.ok   = 1'b1;
          order_we   = (cmd == CMD_ORDER);
          cmd_we     = (cmd != CMD_NOSAVE) && (cmd != CMD_ROUTE);
          // byte k of the packet lands at route entry k-6, checksum excluded
          route_we   = (cmd == CMD_ROUTE) && (idx >= IDX_W'(ROUTE_OFS)) &&
                       (CNT_W'(idx) + CNT_W'(1) < count);
          if (echo_last) begin
            count_next = '0;
            state_next = S_IDLE;
          end else begin
            idx_next   = idx + IDX_W'(1);
            state_next = S_ECHO_RD;
          end
        end
      end
      S_ERR: begin
        if (out_free) begin
          out_load   = 1'b1;
          out_d.kind = KIND_ERR;
          out_d.data = err_byte(err_idx);
          out_d.last = err_last;
          if (err_last) begin
            state_next = S_IDLE;
          end else begin
            err_idx_next = err_idx + ERR_W'(1);
          end
        end
      end
      S_READ: begin
        case (rd_sel)
          STORE_ORDER: rd_ok_next = rd_in_range && v_order[store_raddr];
          STORE_ROUTE: rd_ok_next = rd_in_range && v_route[store_raddr];
          STORE_CMD:   rd_ok_next = rd_in_range && v_cmd[store_raddr];
          default:     rd_ok_next = 1'b0;
        endcase
        state_next = S_READ_OUT;
      end
      S_READ_OUT: begin
        if (out_free) begin
          out_load   = 1'b1;
          out_d.kind = KIND_READ;
          out_d.data = rd_ok ? read_val : 8'h00;
          out_d.last = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      count   <= '0;
      cmd     <= 8'h00;
      turns   <= 8'h00;
      v_order <= '0;
      v_route <= '0;
      v_cmd   <= '0;
    end else begin
      state <= state_next;
      count <= count_next;
      cmd   <= cmd_next;
      turns <= turns_next;
      if (order_we) v_order[idx] <= 1'b1;
      if (route_we) v_route[route_waddr] <= 1'b1;
      if (cmd_we) v_cmd[idx] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    idx       <= idx_next;
    err_idx   <= err_idx_next;
    b0        <= b0_next;
    b1        <= b1_next;
    len       <= len_next;
    last_byte <= last_byte_next;
    rd_sel    <= rd_sel_next;
    rd_idx    <= rd_idx_next;
    rd_ok     <= rd_ok_next;
  end

  cpr_ram #(.WIDTH(8), .DEPTH(BUF_DEPTH)) u_buf (
    .clk   (clk),
    .we    (buf_we),
    .waddr (count[IDX_W-1:0]),
    .wdata (rx_byte),
    .raddr (idx),
    .rdata (buf_rdata)
  );

  cpr_ram #(.WIDTH(8), .DEPTH(BUF_DEPTH)) u_order (
    .clk   (clk),
    .we    (order_we),
    .waddr (idx),
    .wdata (buf_rdata),
    .raddr (store_raddr),
    .rdata (order_rdata)
  );

  cpr_ram #(.WIDTH(8), .DEPTH(BUF_DEPTH)) u_route (
    .clk   (clk),
    .we    (route_we),
    .waddr (route_waddr),
    .wdata (buf_rdata),
    .raddr (store_raddr),
    .rdata (route_rdata)
  );

  cpr_ram #(.WIDTH(8), .DEPTH(BUF_DEPTH)) u_cmd (
    .clk   (clk),
    .we    (cmd_we),
    .waddr (idx),
    .wdata (buf_rdata),
    .raddr (store_raddr),
    .rdata (cmd_rdata)
  );

  cpr_accum u_accum (
    .clk      (clk),
    .ctrl     (acc_ctrl),
    .data     (buf_rdata),
    .ref_byte (last_byte),
    .match    (sum_match)
  );

  cpr_out_reg u_out (
    .clk    (clk),
    .rst    (rst),
    .load   (out_load),
    .item_d (out_d),
    .stall  (out_stall),
    .valid  (out_valid),
    .item_q (out_q),
    .free   (out_free)
  );

  assign out_kind   = out_q.kind;
  assign out_byte   = out_q.data;
  assign last       = out_q.last;
  assign packet_ok  = out_q.ok;
  assign turn_count = out_q.turns;

endmodule
`default_nettype wire

### rtl/core/cpr_checker.sv
`default_nettype none
`include "checksummed_packet_receiver_defines.svh"
module cpr_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       in_valid,
  input wire logic       in_stall,
  input wire logic       action,
  input wire logic [7:0] rx_byte,
  input wire logic [1:0] store_select,
  input wire logic [5:0] read_index,
  input wire logic       out_valid,
  input wire logic       out_stall,
  input wire logic [1:0] out_kind,
  input wire logic [7:0] out_byte,
  input wire logic       last,
  input wire logic       packet_ok,
  input wire logic [7:0] turn_count
);
  import cpr_pkg::*;

  // only echo bytes carry the good-packet flag
  `CPR_CHK(a_ok_only_echo, out_valid, packet_ok == (out_kind == KIND_ECHO))
  // a read produces exactly one result
  `CPR_CHK(a_read_single, out_valid && out_kind == KIND_READ, last)
  `CPR_CHK(a_kind_legal, out_valid, out_kind == KIND_ECHO || out_kind == KIND_ERR || out_kind == KIND_READ)
  // output register comes out of reset empty
  `CPR_CHK_RST(a_reset_empty, rst |=> !out_valid)

endmodule

bind checksummed_packet_receiver cpr_checker u_cpr_checker (.*);
`default_nettype wire

### verif/packet_receiver_checker.sv
module packet_receiver_checker (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         in_valid,
  input  wire logic                         in_stall,
  input  wire logic                         action,
  input  wire logic [7:0]                   rx_byte,
  input  wire logic [1:0]                   store_select,
  input  wire logic [cpr_pkg::RD_IDX_W-1:0] read_index,
  input  wire logic                         out_valid,
  input  wire logic                         out_stall,
  input  wire logic [1:0]                   out_kind,
  input  wire logic [7:0]                   out_byte,
  input  wire logic                         last,
  input  wire logic                         packet_ok,
  input  wire logic [7:0]                   turn_count,
  output int                                fail_count,
  output int                                pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import cpr_pkg::*;

  // fixed reply sent on any framing, overflow or checksum error, first byte on top
  localparam logic [8*ERR_LEN-1:0] ERROR_REPLY = 72'hAA_55_06_00_01_C1_00_01_C8;

  logic [7:0] pkt_buf     [BUF_DEPTH];
  logic [7:0] order_mem   [BUF_DEPTH];
  logic [7:0] route_mem   [BUF_DEPTH];
  logic [7:0] command_mem [BUF_DEPTH];
  int         fill;
  logic [7:0] route_turns;
  out_item_t  awaited_results [$];
  int         mismatches;

  task automatic queue_result(input logic [1:0] kind, input logic [7:0] data,
                              input logic is_last, input logic ok);
    out_item_t r;
    r.kind  = kind;
    r.data  = data;
    r.last  = is_last;
    r.ok    = ok;
    r.turns = route_turns;
    awaited_results.push_back(r);
  endtask

  // works out every result caused by the request on the input channel
  task automatic compute_replies();
    logic [7:0] val;
    logic [7:0] sum;
    logic [7:0] cmd;
    int         len;
    bit         bad;
    bit         complete;
    bad      = 1'b0;
    complete = 1'b0;
    if (action) begin
      val = '0;
      if (read_index < BUF_DEPTH) begin
        case (store_select)
          STORE_ORDER: val = order_mem[read_index];
          STORE_ROUTE: val = route_mem[read_index];
          STORE_CMD:   val = command_mem[read_index];
          default:     val = '0;
        endcase
      end
      queue_result(KIND_READ, val, 1'b1, 1'b0);
      return;
    end
    if (fill >= BUF_DEPTH) fill = 0;
    pkt_buf[fill] = rx_byte;
    fill++;
    if (fill >= BUF_DEPTH) begin
      bad = 1'b1;
    end else if (pkt_buf[0] != SYNC0) begin
      bad = 1'b1;
    end else if (fill > 3) begin
      if (pkt_buf[1] != SYNC1) begin
        bad = 1'b1;
      end else if (fill >= int'(pkt_buf[2]) + 3) begin
        sum = '0;
        for (int i = 0; i < fill - 1; i++) sum += pkt_buf[i];
        if (sum == pkt_buf[fill-1]) complete = 1'b1;
        else bad = 1'b1;
      end
    end
    if (bad) begin
      fill = 0;
      for (int m = 0; m < ERR_LEN; m++)
        queue_result(KIND_ERR, ERROR_REPLY[8*(ERR_LEN-1-m) +: 8], m == ERR_LEN - 1, 1'b0);
    end else if (complete) begin
      len = fill;
      // command slot is not cleared between packets, short ones see an old value
      cmd = pkt_buf[CMD_POS];
      for (int k = 0; k < len; k++) begin
        if (cmd == CMD_ORDER) order_mem[k] = pkt_buf[k];
        if (cmd == CMD_ROUTE && k + ROUTE_OFS < len - 1) begin
          route_mem[k] = pkt_buf[k+ROUTE_OFS];
          route_turns  = 8'(len - ROUTE_OFS - 1);
        end
        if (cmd != CMD_NOSAVE && cmd != CMD_ROUTE) command_mem[k] = pkt_buf[k];
      end
      for (int k = 0; k < len; k++) queue_result(KIND_ECHO, pkt_buf[k], k == len - 1, 1'b1);
      fill = 0;
    end
  endtask

  task automatic compare_output();
    out_item_t exp_r;
    if (awaited_results.size() == 0) begin
      $error("unexpected result: out_kind %0d out_byte %02h", out_kind, out_byte);
      mismatches++;
      return;
    end
    exp_r = awaited_results.pop_front();
    if (out_kind !== exp_r.kind) begin
      $error("out_kind: expected %0d, got %0d", exp_r.kind, out_kind);
      mismatches++;
    end
    if (out_byte !== exp_r.data) begin
      $error("out_byte: expected %02h, got %02h", exp_r.data, out_byte);
      mismatches++;
    end
    if (last !== exp_r.last) begin
      $error("last: expected %0d, got %0d", exp_r.last, last);
      mismatches++;
    end
    if (packet_ok !== exp_r.ok) begin
      $error("packet_ok: expected %0d, got %0d", exp_r.ok, packet_ok);
      mismatches++;
    end
    if (turn_count !== exp_r.turns) begin
      $error("turn_count: expected %0d, got %0d", exp_r.turns, turn_count);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < BUF_DEPTH; i++) begin
        pkt_buf[i]     = '0;
        order_mem[i]   = '0;
        route_mem[i]   = '0;
        command_mem[i] = '0;
      end
      fill        = 0;
      route_turns = '0;
      mismatches  = 0;
      awaited_results.delete();
    end else begin
      if (out_valid && !out_stall) compare_output();
      if (in_valid && !in_stall) compute_replies();
    end
    pending    <= awaited_results.size();
    fail_count <= mismatches;
  end

endmodule

### verif/checksummed_packet_receiver_tb.sv
module checksummed_packet_receiver_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import cpr_pkg::*;

  localparam int DIRECTED_REQS = 26;
  localparam int RANDOM_REQS   = 194;
  localparam int HOLD_CYCLES   = 400;
  localparam int DRAIN_CYCLES  = 120;

  logic                clk;
  logic                rst          = 1'b1;
  logic                in_valid     = 1'b0;
  logic                in_stall;
  logic                action       = 1'b0;
  logic [7:0]          rx_byte      = '0;
  logic [1:0]          store_select = '0;
  logic [RD_IDX_W-1:0] read_index   = '0;
  logic                out_valid;
  logic                out_stall    = 1'b0;
  logic [1:0]          out_kind;
  logic [7:0]          out_byte;
  logic                last;
  logic                packet_ok;
  logic [7:0]          turn_count;
  int                  fail_count;
  int                  pending;

  int requests_sent = 0;
  bit no_gaps       = 1'b0;
  bit hold_out      = 1'b0;

  checksummed_packet_receiver dut (.*);

  packet_receiver_checker checker_i (.*);

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  function automatic int idle_cycles();
    int r;
    if (no_gaps) return 0;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // mostly short packets, a few near the buffer limit
  function automatic int pick_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) return $urandom_range(28, 32);
    if (r < 25) return $urandom_range(0, 2);
    return $urandom_range(3, 12);
  endfunction

  function automatic logic [7:0] pick_cmd();
    case ($urandom_range(0, 3))
      0:       return CMD_ORDER;
      1:       return CMD_NOSAVE;
      2:       return CMD_ROUTE;
      default: return 8'($urandom);
    endcase
  endfunction

  task automatic send_request(input logic act, input logic [7:0] b, input logic [1:0] sel,
                              input logic [RD_IDX_W-1:0] idx);
    int gap;
    gap = idle_cycles();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    action       <= act;
    rx_byte      <= b;
    store_select <= sel;
    read_index   <= idx;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    requests_sent++;
  endtask

  task automatic send_byte(input logic [7:0] b);
    send_request(1'b0, b, 2'($urandom), RD_IDX_W'($urandom));
  endtask

  task automatic send_read(input logic [1:0] sel, input logic [RD_IDX_W-1:0] idx);
    send_request(1'b1, 8'($urandom), sel, idx);
  endtask

  // header, length, payload with the command in its slot, then the additive sum
  task automatic send_packet(input int len_field, input logic [7:0] cmd, input bit bad_sum);
    logic [7:0] frame [$];
    logic [7:0] sum;
    int         n;
    n = len_field + 3;
    if (n < 4) n = 4;
    if (n > BUF_DEPTH) n = BUF_DEPTH;
    frame.push_back(SYNC0);
    frame.push_back(SYNC1);
    frame.push_back(8'(len_field));
    for (int i = 3; i < n - 1; i++) frame.push_back(i == CMD_POS ? cmd : 8'($urandom));
    sum = '0;
    foreach (frame[i]) sum += frame[i];
    if (bad_sum) sum += 8'($urandom_range(1, 255));
    frame.push_back(sum);
    foreach (frame[i]) send_byte(frame[i]);
  endtask

  // output side backpressure, with one long hold-off on request
  initial begin
    int  r;
    int  span;
    bit  level;
    @(posedge clk);
    forever begin
      if (hold_out) begin
        hold_out = 1'b0;
        level    = 1'b1;
        span     = HOLD_CYCLES;
      end else begin
        r = $urandom_range(0, 9);
        if (r < 3) begin
          level = 1'b0;
          span  = $urandom_range(10, 60);
        end else if (r < 6) begin
          level = 1'b0;
          span  = $urandom_range(1, 4);
        end else if (r < 9) begin
          level = 1'b1;
          span  = $urandom_range(1, 3);
        end else begin
          level = 1'b1;
          span  = $urandom_range(20, 60);
        end
      end
      out_stall <= level;
      repeat (span) @(posedge clk);
    end
  end

  initial begin
    int choice;
    bit hold_done;
    hold_done = 1'b0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    send_read(STORE_ORDER, '0);
    send_read(2'd3, '1);
    send_read(STORE_CMD, RD_IDX_W'(BUF_DEPTH - 1));
    send_byte(8'h00);
    send_byte(SYNC0);
    send_byte(8'h00);
    send_byte(8'h05);
    send_byte(8'h12);
    send_packet(0, 8'h00, 1'b0);
    send_packet(1, 8'h00, 1'b1);
    send_packet(6, CMD_ROUTE, 1'b0);
    send_read(STORE_ROUTE, RD_IDX_W'(1));

    while (requests_sent < DIRECTED_REQS + RANDOM_REQS) begin
      if (!hold_done && requests_sent >= DIRECTED_REQS + 60) begin
        hold_out  = 1'b1;
        hold_done = 1'b1;
      end
      no_gaps = ($urandom_range(0, 3) == 0);
      choice  = $urandom_range(0, 99);
      if (choice < 50) begin
        send_packet(pick_len(), pick_cmd(), 1'b0);
      end else if (choice < 60) begin
        send_packet(pick_len(), pick_cmd(), 1'b1);
      end else if (choice < 64) begin
        send_byte(SYNC0 ^ 8'($urandom_range(1, 255)));
      end else if (choice < 68) begin
        send_byte(SYNC0);
        send_byte(SYNC1 ^ 8'($urandom_range(1, 255)));
        send_byte(8'($urandom));
        send_byte(8'($urandom));
      end else if (choice < 71) begin
        // length that can never fit, runs into the overflow
        send_packet($urandom_range(BUF_DEPTH - 3, 255), pick_cmd(), 1'b0);
      end else if (choice < 88) begin
        if ($urandom_range(0, 4) == 0) send_read(2'($urandom), RD_IDX_W'($urandom));
        else send_read(2'($urandom), RD_IDX_W'($urandom_range(0, BUF_DEPTH - 1)));
      end else begin
        send_byte(8'($urandom));
      end
    end

    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("PASS checksummed_packet_receiver");
    end else begin
      $display("FAIL checksummed_packet_receiver");
    end
    $finish;
  end

  initial begin
    #40_000_000;
    $display("FAIL checksummed_packet_receiver");
    $finish;
  end

endmodule

### filelist.f
+incdir+rtl/core
rtl/core/cpr_pkg.sv
rtl/core/cpr_ram.sv
rtl/core/cpr_accum.sv
rtl/core/cpr_out_reg.sv
rtl/core/checksummed_packet_receiver.sv
rtl/core/cpr_checker.sv
verif/packet_receiver_checker.sv
verif/checksummed_packet_receiver_tb.sv
